@@ sv/ir90_pkg.sv @@
// ----------------------------------------------------------------------------
// ir90_pkg
// Shared types and constants of the 90 degree image rotation frame store.
// ----------------------------------------------------------------------------
package ir90_pkg;

  // Width of the dimension registers and of the fetch position counters.
  localparam int unsigned DimW = 9;
  // Width of the store counter: holds up to 511 * 511 pixels.
  localparam int unsigned CntW = 2 * DimW;
  // Width of one channel word on the stream ports.
  localparam int unsigned ChanW = 32;
  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_ROTATE_DIR   = 2'd2,
    CFG_PIXEL_FORMAT = 2'd3
  } ir90_cfg_idx_e;

  // Request kinds carried in tuser.
  typedef enum logic {
    REQ_STORE = 1'b0,
    REQ_FETCH = 1'b1
  } ir90_req_e;

  // Rotation direction and pixel format codes.
  localparam logic DirCw  = 1'b0;
  localparam logic FmtRgb = 1'b0;

  // Configuration register set.
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            rotate_dir;
    logic            pixel_format;
  } ir90_cfg_t;

  // Side information of one fetch, kept beside the memory read.
  typedef struct packed {
    logic zero_all;
    logic zero_alpha;
    logic last;
  } ir90_fetch_info_t;

  // A zero dimension counts as one, anything above the maximum as the maximum.
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, int unsigned max_dim);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > max_dim) begin
      r = DimW'(max_dim);
    end
    return r;
  endfunction

endpackage

@@ sv/ir90_ram.sv @@
// ----------------------------------------------------------------------------
// ir90_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ir90_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 65536,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One access per cycle: write, or read into the output register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ir90_addr_gen.sv @@
// ----------------------------------------------------------------------------
// ir90_addr_gen
// Store counter and rotated fetch position, and the memory address of each
// accepted word.
// ----------------------------------------------------------------------------
module ir90_addr_gen #(
  parameter int unsigned MaxDim = 256,
  localparam int unsigned Depth = MaxDim * MaxDim,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ir90_pkg::ir90_cfg_t        cfg_i,
  input  logic                       accept_i,
  input  logic                       is_fetch_i,
  output logic                       mem_en_o,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_addr_o,
  output ir90_pkg::ir90_fetch_info_t info_o
);

  import ir90_pkg::*;

  logic [CntW-1:0] store_cnt_q, store_cnt_d;
  logic [DimW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;

  logic [DimW-1:0] dim_w, dim_h;
  logic [CntW-1:0] total;
  logic            store_ok;
  logic            out_of_frame;
  logic [DimW-1:0] mul_a, add_b;
  logic [CntW-1:0] fetch_addr;
  logic [DimW-1:0] col_inc, row_inc;
  logic            col_wrap, frame_end;

  // Effective dimensions and the frame size.
  assign dim_w    = clamp_dim(cfg_i.width, MaxDim);
  assign dim_h    = clamp_dim(cfg_i.height, MaxDim);
  assign total    = CntW'(dim_w) * CntW'(dim_h);
  assign store_ok = store_cnt_q < total;

  // Source address of the current rotated position.
  assign out_of_frame = (col_q >= dim_h) || (row_q >= dim_w);
  assign mul_a = (cfg_i.rotate_dir == DirCw) ? col_q : (dim_h - DimW'(1) - col_q);
  assign add_b = (cfg_i.rotate_dir == DirCw) ? (dim_w - DimW'(1) - row_q) : row_q;
  assign fetch_addr = CntW'(mul_a) * CntW'(dim_w) + CntW'(add_b);

  // Next fetch position in the rotated raster order.
  assign col_inc   = col_q + DimW'(1);
  assign col_wrap  = col_inc >= dim_h;
  assign row_inc   = row_q + DimW'(1);
  assign frame_end = col_wrap && (row_inc >= dim_w);

  always_comb begin
    store_cnt_d = store_cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    if (accept_i) begin
      if (!is_fetch_i) begin
        if (store_ok) begin
          store_cnt_d = store_cnt_q + CntW'(1);
        end
      end else if (out_of_frame || frame_end) begin
        store_cnt_d = '0;
        col_d       = '0;
        row_d       = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_inc;
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_cnt_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      store_cnt_q <= store_cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  // Memory request: a dropped store does not touch the memory.
  assign mem_en_o   = accept_i && (is_fetch_i || store_ok);
  assign mem_we_o   = !is_fetch_i;
  assign mem_addr_o = is_fetch_i ? AddrW'(fetch_addr) : AddrW'(store_cnt_q);

  assign info_o.zero_all   = out_of_frame;
  assign info_o.zero_alpha = cfg_i.pixel_format == FmtRgb;
  assign info_o.last       = out_of_frame || frame_end;

endmodule

@@ sv/ir90_out_fifo.sv @@
// ----------------------------------------------------------------------------
// ir90_out_fifo
// Two-entry result buffer between the memory read and the output stream.
// ----------------------------------------------------------------------------
module ir90_out_fifo #(
  parameter int unsigned Width = 129
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  output logic [1:0]       count_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;

  // Occupancy tracking.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

@@ sv/image_rotate_90.sv @@
// ----------------------------------------------------------------------------
// image_rotate_90
// Frame store that takes a source image in raster order and returns it
// rotated by 90 degrees, again in raster order.
//
//   Channel   Direction  Word                                  Handshake
//   s_axis    in         tuser: request kind (0 store, 1 fetch) tvalid/tready
//                        tdata: red, green, blue, alpha
//   m_axis    out        tdata: red, green, blue, alpha          tvalid/tready
//                        tlast: final pixel of the rotated frame
//   cfg       in         index 0 width, 1 height, 2 direction,  cfg_we_i
//                        3 pixel format
//
// One word is taken per cycle while s_axis_tready is high; each word but a
// store beyond the frame makes one access to the single-port pixel memory.
// A fetch reads the memory into the RAM output register, then enters the
// result buffer, from whose head it shows on m_axis.
// Reset clears the counters and sets the configuration to 256 by 256, clockwise,
// RGB; the pixel memory is not cleared, so a fetch may read unwritten entries.
// With m_axis stalled, s_axis stops taking words, stores included, once the
// buffered results and the read in flight add up to the two buffer entries.
// ----------------------------------------------------------------------------
module image_rotate_90 #(
  parameter int unsigned MAX_DIM      = 256,
  parameter int unsigned CHANNEL_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream; tdata from the lowest bit: in_red, in_green, in_blue, in_alpha.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [4*ir90_pkg::ChanW-1:0]      s_axis_tdata,
  // tuser: req_type.
  input  logic                              s_axis_tuser,
  // Output stream; tdata from the lowest bit: out_red, out_green, out_blue, out_alpha.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [4*ir90_pkg::ChanW-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [ir90_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ir90_pkg::DimW-1:0]         cfg_data_i
);

  import ir90_pkg::*;

  localparam int unsigned Depth  = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PixW   = 4 * CHANNEL_BITS;
  localparam int unsigned ResW   = 4 * ChanW + 1;

  ir90_cfg_t        cfg_q;
  ir90_fetch_info_t info, info_q;
  logic             pend_q;
  logic             accept, is_fetch;
  logic             mem_en, mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [PixW-1:0]  wr_pix, rd_pix;
  logic [ResW-1:0]  res_data, fifo_data;
  logic             fifo_pop;
  logic [1:0]       fifo_count;
  logic [ChanW-1:0] res_red, res_green, res_blue, res_alpha;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width        <= DimW'(256);
      cfg_q.height       <= DimW'(256);
      cfg_q.rotate_dir   <= 1'b0;
      cfg_q.pixel_format <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (ir90_cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  cfg_q.width        <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_q.height       <= cfg_data_i;
        CFG_ROTATE_DIR:   cfg_q.rotate_dir   <= cfg_data_i[0];
        CFG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input acceptance: room for the read in flight and the buffered results.
  assign fifo_pop      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (3'(fifo_count) + 3'(pend_q)) < (3'd2 + 3'(fifo_pop));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_fetch      = s_axis_tuser == REQ_FETCH;

  ir90_addr_gen #(
    .MaxDim (MAX_DIM)
  ) u_addr_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .is_fetch_i (is_fetch),
    .mem_en_o   (mem_en),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .info_o     (info)
  );

  // Keep the low channel bits of each word.
  assign wr_pix = {s_axis_tdata[3*ChanW +: CHANNEL_BITS],
                   s_axis_tdata[2*ChanW +: CHANNEL_BITS],
                   s_axis_tdata[1*ChanW +: CHANNEL_BITS],
                   s_axis_tdata[0*ChanW +: CHANNEL_BITS]};

  ir90_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (wr_pix),
    .rdata_o (rd_pix)
  );

  // Marks a fetch read in flight, to be pushed into the result buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept && is_fetch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_fetch) begin
      info_q <= info;
    end
  end

  // Form the result word from the read data.
  always_comb begin
    res_red   = ChanW'(rd_pix[0*CHANNEL_BITS +: CHANNEL_BITS]);
    res_green = ChanW'(rd_pix[1*CHANNEL_BITS +: CHANNEL_BITS]);
    res_blue  = ChanW'(rd_pix[2*CHANNEL_BITS +: CHANNEL_BITS]);
    res_alpha = ChanW'(rd_pix[3*CHANNEL_BITS +: CHANNEL_BITS]);
    if (info_q.zero_all) begin
      res_red   = '0;
      res_green = '0;
      res_blue  = '0;
      res_alpha = '0;
    end else if (info_q.zero_alpha) begin
      res_alpha = '0;
    end
  end

  assign res_data = {info_q.last, res_alpha, res_blue, res_green, res_red};

  ir90_out_fifo #(
    .Width (ResW)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pend_q),
    .push_data_i (res_data),
    .pop_i       (fifo_pop),
    .valid_o     (m_axis_tvalid),
    .data_o      (fifo_data),
    .count_o     (fifo_count)
  );

  assign m_axis_tdata = fifo_data[4*ChanW-1:0];
  assign m_axis_tlast = fifo_data[4*ChanW];

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 90 degree image rotation frame store. Frames
// of random and extreme pixels are stored and fetched back in rotated order,
// under random idling on both streams. Each fetch is predicted from a local
// copy of the pixel memory and the position counters, and every word on the
// output stream is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import ir90_pkg::*;

  localparam int unsigned Side        = 256;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned RandomWords = 400;
  localparam int unsigned MaxReports  = 10;
  localparam logic        DirCcw      = ~DirCw;
  localparam logic        FmtRgba     = ~FmtRgb;

  typedef enum int {
    FRAME_FULL,
    FRAME_SHORT,
    FRAME_MIXED
  } frame_kind_e;

  // One word waiting to be offered on the input stream.
  typedef struct packed {
    ir90_req_e          kind;
    logic [4*ChanW-1:0] pixel;
  } pixel_req_t;

  // One rotated pixel as it should leave the block; chan[0] is red.
  typedef struct packed {
    logic [3:0][ChanW-1:0] chan;
    logic                  last;
  } rot_pixel_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [4*ChanW-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [4*ChanW-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [DimW-1:0]      cfg_data_i    = '0;

  // Stimulus and expectations.
  pixel_req_t  pixel_words_q[$];
  rot_pixel_t  rotated_pixels_q[$];
  int unsigned words_queued  = 0;
  int unsigned words_taken   = 0;
  int unsigned pixels_seen   = 0;
  int unsigned mismatches    = 0;
  logic        word_taken    = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  string       chan_name [4] = '{"red", "green", "blue", "alpha"};

  // Model of the frame store: memory, counters and registers.
  logic [4*ChanW-1:0] frame_mem [int];
  int unsigned        stored_cnt = 0;
  int unsigned        out_col    = 0;
  int unsigned        out_row    = 0;
  logic [DimW-1:0]    reg_width  = 9'd256;
  logic [DimW-1:0]    reg_height = 9'd256;
  logic               reg_dir    = DirCw;
  logic               reg_fmt    = FmtRgb;

  // Generator's view of the geometry and of how much memory holds data.
  int unsigned cur_w   = Side;
  int unsigned cur_h   = Side;
  int unsigned covered = 0;

  image_rotate_90 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // A zero dimension counts as one pixel, anything above the maximum as the maximum.
  function automatic int unsigned eff_dim(input logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > Side) return Side;
    return v;
  endfunction

  // Works out what one accepted word does to the frame store.
  task automatic rotate_predict(input ir90_req_e kind, input logic [4*ChanW-1:0] pixel);
    int unsigned w;
    int unsigned h;
    int unsigned addr;
    rot_pixel_t  px;
    w  = eff_dim(reg_width);
    h  = eff_dim(reg_height);
    px = '0;
    if (kind == REQ_STORE) begin
      // Stores beyond the frame are dropped.
      if (stored_cnt < w * h) begin
        frame_mem[stored_cnt] = pixel;
        stored_cnt++;
      end
    end else begin
      if (out_col >= h || out_row >= w) begin
        // Position left outside a frame that has since shrunk: blank and rearm.
        px.last    = 1'b1;
        stored_cnt = 0;
        out_col    = 0;
        out_row    = 0;
      end else begin
        if (reg_dir == DirCw) begin
          addr = out_col * w + (w - 1 - out_row);
        end else begin
          addr = (h - 1 - out_col) * w + out_row;
        end
        if (frame_mem.exists(addr)) begin
          px.chan = frame_mem[addr];
        end
        if (reg_fmt == FmtRgb) begin
          px.chan[3] = '0;
        end
        out_col++;
        if (out_col >= h) begin
          out_col = 0;
          out_row++;
        end
        if (out_row >= w) begin
          px.last    = 1'b1;
          stored_cnt = 0;
          out_col    = 0;
          out_row    = 0;
        end
      end
      rotated_pixels_q.push_back(px);
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Input side: offer the next word once the current one has been taken.
  always @(negedge clk_i) begin : driver
    pixel_req_t next_word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      if (pixel_words_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = pixel_words_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_word.kind;
        s_axis_tdata  <= next_word.pixel;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random back-pressure, and the occasional long hold-off.
  always @(negedge clk_i) begin : receiver
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (holds_served != hold_requests) begin
      m_axis_tready <= 1'b0;
      holds_served = holds_served + 1;
      hold_left    = LongHold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Samples both streams and the register port at the rising edge.
  always @(posedge clk_i) begin : monitor
    rot_pixel_t got;
    rot_pixel_t want;
    if (!rst_ni) begin
      reg_width  = 9'd256;
      reg_height = 9'd256;
      reg_dir    = DirCw;
      reg_fmt    = FmtRgb;
      stored_cnt = 0;
      out_col    = 0;
      out_row    = 0;
      word_taken = 1'b0;
    end else begin
      // Register writes take effect in the model at the same edge as in the block.
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  reg_width  = cfg_data_i;
          CFG_IMAGE_HEIGHT: reg_height = cfg_data_i;
          CFG_ROTATE_DIR:   reg_dir    = cfg_data_i[0];
          CFG_PIXEL_FORMAT: reg_fmt    = cfg_data_i[0];
          default: ;
        endcase
      end
      // Check an output word against the oldest expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        got.chan = m_axis_tdata;
        got.last = m_axis_tlast;
        if (rotated_pixels_q.size() == 0) begin
          note_mismatch($sformatf("pixel %0d arrived with none expected", pixels_seen));
        end else begin
          want = rotated_pixels_q.pop_front();
          for (int c = 0; c < 4; c++) begin
            if (got.chan[c] !== want.chan[c]) begin
              note_mismatch($sformatf("pixel %0d %s: expected %h, got %h", pixels_seen,
                                      chan_name[c], want.chan[c], got.chan[c]));
            end
          end
          if (got.last !== want.last) begin
            note_mismatch($sformatf("pixel %0d tlast: expected %b, got %b", pixels_seen,
                                    want.last, got.last));
          end
        end
        pixels_seen++;
      end
      // Predict from every word accepted on the input stream.
      word_taken = s_axis_tvalid && s_axis_tready;
      if (word_taken) begin
        rotate_predict(ir90_req_e'(s_axis_tuser), s_axis_tdata);
        words_taken++;
      end
    end
  end

  task automatic queue_pixel(input ir90_req_e kind, input logic [4*ChanW-1:0] pixel);
    pixel_req_t w;
    w.kind  = kind;
    w.pixel = pixel;
    pixel_words_q.push_back(w);
    words_queued++;
  endtask

  // Random channel words, now and then all zeros or all ones.
  task automatic queue_random(input ir90_req_e kind);
    logic [4*ChanW-1:0] pixel;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(7))
        0:       pixel[c*ChanW +: ChanW] = '0;
        1:       pixel[c*ChanW +: ChanW] = '1;
        default: pixel[c*ChanW +: ChanW] = $urandom;
      endcase
    end
    queue_pixel(kind, pixel);
  endtask

  // Waits until every word has been taken and every result has come back.
  task automatic wait_idle(input int unsigned extra);
    do @(negedge clk_i); while (words_taken != words_queued || rotated_pixels_q.size() != 0);
    repeat (extra) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input ir90_cfg_idx_e idx, input logic [DimW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic set_geometry(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                              input logic dir, input logic fmt);
    wait_idle(DrainCycles);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_ROTATE_DIR, DimW'(dir));
    write_reg(CFG_PIXEL_FORMAT, DimW'(fmt));
    cur_w = eff_dim(w);
    cur_h = eff_dim(h);
    @(posedge clk_i);
  endtask

  // One frame from a rearmed state, ending on its final fetch. Short and
  // mixed frames read stale pixels, so they need the whole frame written before.
  task automatic run_frame(input frame_kind_e kind, input bit pause_midway,
                           input bit hold_before_fetch);
    int unsigned area;
    int unsigned stores;
    int unsigned stores_total;
    area = cur_w * cur_h;
    if (covered < area) begin
      kind = FRAME_FULL;
    end
    case (kind)
      FRAME_FULL:  stores = area + (($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0);
      FRAME_SHORT: stores = $urandom_range(area - 1);
      default:     stores = $urandom_range(2 * area);
    endcase
    stores_total = stores;
    if (kind != FRAME_MIXED) begin
      repeat (stores) queue_random(REQ_STORE);
      stores = 0;
    end
    for (int unsigned n = 0; n < area; n++) begin
      while (stores != 0 && ($urandom_range(1) == 0 || n == area - 1)) begin
        queue_random(REQ_STORE);
        stores--;
      end
      if (hold_before_fetch && n == 0) begin
        wait_idle(0);
        hold_requests++;
      end
      if (pause_midway && n == area / 2) begin
        wait_idle(0);
      end
      queue_random(REQ_FETCH);
    end
    if (stores_total > area) stores_total = area;
    if (stores_total > covered) covered = stores_total;
  endtask

  task automatic select_idling(input int unsigned phase);
    case (phase)
      0: begin
        send_idle_pct = 18;
        recv_idle_pct = 45;
      end
      1: begin
        send_idle_pct = 45;
        recv_idle_pct = 18;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Run time limit.
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus.
  initial begin
    logic [4*ChanW-1:0] corner_pixels [6];
    int unsigned        frame_no;
    frame_kind_e        kind;

    corner_pixels = '{'0, '1, {4{32'h8000_0000}}, {4{32'h0000_0001}},
                      {4{32'h5555_5555}}, {4{32'hAAAA_AAAA}}};
    select_idling(0);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Extreme channel words in RGB format, clockwise; one store past the frame.
    set_geometry(9'd2, 9'd3, DirCw, FmtRgb);
    for (int i = 0; i < 6; i++) queue_pixel(REQ_STORE, corner_pixels[i]);
    queue_random(REQ_STORE);
    repeat (6) queue_random(REQ_FETCH);
    covered = 6;

    // Same pixels counter-clockwise with alpha.
    set_geometry(9'd2, 9'd3, DirCcw, FmtRgba);
    repeat (6) queue_random(REQ_FETCH);

    // Fetch position left beyond a frame whose width has shrunk.
    set_geometry(9'd3, 9'd2, DirCw, FmtRgba);
    repeat (4) queue_random(REQ_FETCH);
    wait_idle(DrainCycles);
    write_reg(CFG_IMAGE_WIDTH, 9'd2);
    cur_w = 2;
    @(posedge clk_i);
    queue_random(REQ_FETCH);

    // And beyond a frame whose height has shrunk.
    set_geometry(9'd2, 9'd3, DirCcw, FmtRgb);
    repeat (2) queue_random(REQ_FETCH);
    wait_idle(DrainCycles);
    write_reg(CFG_IMAGE_HEIGHT, 9'd2);
    cur_h = 2;
    @(posedge clk_i);
    queue_random(REQ_FETCH);

    // Random frames, mostly small. The first fills the largest random size;
    // the second pauses midway and starts its fetches under a long hold-off.
    frame_no = 0;
    while (words_queued < RandomWords) begin
      select_idling(words_queued * 3 / RandomWords);
      if (frame_no == 0) begin
        set_geometry(9'd8, 9'd8, DirCcw, FmtRgb);
        run_frame(FRAME_FULL, 1'b0, 1'b0);
      end else if (frame_no == 1) begin
        set_geometry(9'd3, 9'd8, DirCw, FmtRgba);
        run_frame(FRAME_FULL, 1'b1, 1'b1);
      end else begin
        if ($urandom_range(2) == 0) begin
          set_geometry(DimW'($urandom_range(8)), DimW'($urandom_range(8)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        case ($urandom_range(9))
          0, 1:    kind = FRAME_SHORT;
          2:       kind = FRAME_MIXED;
          default: kind = FRAME_FULL;
        endcase
        run_frame(kind, $urandom_range(7) == 0, 1'b0);
      end
      frame_no++;
    end

    wait_idle(DrainCycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
